@@ src/uiam_pkg.sv @@
// Package for the utilization idle-alarm monitor.
// Holds widths, ring geometry, the reciprocal for the window average and
// the configuration register indexes. No dependencies.
package uiam_pkg;

    localparam int TICK_W   = 64;
    localparam int NUM_TICK = 8;
    localparam int PM_W     = 10;
    localparam int THR_W    = 7;
    localparam int RUN_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int WINDOW  = 30;
    localparam int RING_AW = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SUM_W   = $clog2(1000 * WINDOW + 1);

    // floor(sum / WINDOW) as (sum * AVG_MULT) >> AVG_SHIFT, exact for sum < 2**SUM_W
    localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int AVG_MULT  = ((2 ** AVG_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int AVG_PROD_W = SUM_W + AVG_SHIFT;

    // busy * 1000 and the percent products share one width
    localparam int PROD_W = TICK_W + PM_W;
    localparam int STEP_W = $clog2(PM_W);

    localparam logic [PM_W-1:0] PERMILLE_FULL = PM_W'(1000);
    localparam logic [PM_W-1:0] PERCENT_FULL  = PM_W'(100);

    localparam logic [THR_W-1:0] THR_RESET   = THR_W'(30);
    localparam logic [RUN_W-1:0] LIMIT_RESET = RUN_W'(30);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = CFG_IDX_W'(1);

endpackage

@@ src/uiam_if.sv @@
// Channel interfaces of the utilization idle-alarm monitor: snapshot input,
// result output and configuration write. Depends on uiam_pkg.
interface uiam_in_if;
    logic                          valid;
    logic                          ready;
    logic [uiam_pkg::TICK_W-1:0]   user_ticks;
    logic [uiam_pkg::TICK_W-1:0]   nice_ticks;
    logic [uiam_pkg::TICK_W-1:0]   system_ticks;
    logic [uiam_pkg::TICK_W-1:0]   idle_ticks;
    logic [uiam_pkg::TICK_W-1:0]   iowait_ticks;
    logic [uiam_pkg::TICK_W-1:0]   irq_ticks;
    logic [uiam_pkg::TICK_W-1:0]   softirq_ticks;
    logic [uiam_pkg::TICK_W-1:0]   steal_ticks;

    modport source (output valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
                    iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
                    input ready);
    modport sink   (input valid, user_ticks, nice_ticks, system_ticks, idle_ticks,
                    iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
                    output ready);
endinterface

interface uiam_out_if;
    logic                        valid;
    logic                        ready;
    logic                        measured;
    logic [uiam_pkg::PM_W-1:0]   utilization_permille;
    logic                        window_full;
    logic [uiam_pkg::PM_W-1:0]   average_permille;
    logic [uiam_pkg::RUN_W-1:0]  low_run_before;
    logic                        alert;

    modport source (output valid, measured, utilization_permille, window_full,
                    average_permille, low_run_before, alert,
                    input ready);
    modport sink   (input valid, measured, utilization_permille, window_full,
                    average_permille, low_run_before, alert,
                    output ready);
endinterface

interface uiam_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [uiam_pkg::CFG_IDX_W-1:0]   index;
    logic [uiam_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/utilization_idle_alarm_monitor.sv @@
// Top level of the utilization idle-alarm monitor: snapshot sequencer,
// shift-add products, restoring divider and the reading ring memory.
// Depends on uiam_pkg and the interfaces in uiam_if.sv.
//
//   channel | dir | beat
//   i_in    | in  | one snapshot of eight 64-bit tick counters
//   o_out   | out | one result per snapshot
//   i_cfg   | in  | register write: index 0 threshold, index 1 run limit
//
// After accept a snapshot passes the counter sum, delta and busy steps, the
// shift-add products and the divider steps, then the ring, average and output
// steps. A baseline snapshot goes from the delta step straight to output.
// A new snapshot is taken once the sequencer is back in idle; the result
// register lets it run ahead of one waiting result beat, then it stalls in done.
// i_rst_n is synchronous, active low; the ring memory needs no clearing.
// Configuration writes are taken whenever reset is released.
module utilization_idle_alarm_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uiam_in_if.sink     i_in,
    uiam_out_if.source  o_out,
    uiam_cfg_if.sink    i_cfg
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SUM   = 9'b000000010,
        S_DELTA = 9'b000000100,
        S_BUSY  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_RING  = 9'b001000000,
        S_AVG   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;

    // control
    logic [2:0]                          r_k;
    logic [uiam_pkg::STEP_W-1:0]         r_j;
    logic                                r_have_base;
    logic [uiam_pkg::RING_AW-1:0]        r_wpos;
    logic [uiam_pkg::FILL_W-1:0]         r_fill;
    logic [uiam_pkg::SUM_W-1:0]          r_sum;
    logic [uiam_pkg::RUN_W-1:0]          r_low_run;
    logic [uiam_pkg::THR_W-1:0]          r_thr;
    logic [uiam_pkg::RUN_W-1:0]          r_limit;
    logic                                r_ov;

    // datapath
    logic [uiam_pkg::TICK_W-1:0]         r_field [uiam_pkg::NUM_TICK];
    logic [uiam_pkg::TICK_W-1:0]         r_total;
    logic [uiam_pkg::TICK_W-1:0]         r_idle;
    logic [uiam_pkg::TICK_W-1:0]         r_last_total;
    logic [uiam_pkg::TICK_W-1:0]         r_prev_idle;
    logic [uiam_pkg::TICK_W-1:0]         r_td;
    logic [uiam_pkg::TICK_W-1:0]         r_id;
    logic [uiam_pkg::TICK_W-1:0]         r_busy;
    logic                                r_td_zero;
    logic                                r_sat;
    logic [uiam_pkg::PROD_W-1:0]         r_num;
    logic [uiam_pkg::PROD_W-1:0]         r_p100;
    logic [uiam_pkg::PROD_W-1:0]         r_pthr;
    logic [uiam_pkg::PM_W-1:0]           r_q;
    logic [uiam_pkg::AVG_PROD_W-1:0]     r_avg_prod;

    logic                                r_res_measured;
    logic [uiam_pkg::PM_W-1:0]           r_res_util;
    logic                                r_res_full;
    logic [uiam_pkg::RUN_W-1:0]          r_res_before;
    logic                                r_res_alert;

    logic                                r_o_measured;
    logic [uiam_pkg::PM_W-1:0]           r_o_util;
    logic                                r_o_full;
    logic [uiam_pkg::PM_W-1:0]           r_o_avg;
    logic [uiam_pkg::RUN_W-1:0]          r_o_before;
    logic                                r_o_alert;

    // reading ring
    logic [uiam_pkg::PM_W-1:0]           r_ring [uiam_pkg::WINDOW];
    logic [uiam_pkg::PM_W-1:0]           r_ring_rd;

    logic                                n_in_acc;
    logic                                n_out_acc;
    logic                                n_out_load;
    logic [uiam_pkg::PROD_W-1:0]         n_busy_sh;
    logic [uiam_pkg::PROD_W-1:0]         n_td_sh;
    logic [uiam_pkg::PM_W-1:0]           n_thr_ext;
    logic [uiam_pkg::PM_W-1:0]           n_util;
    logic [uiam_pkg::SUM_W-1:0]          n_sum;
    logic [uiam_pkg::FILL_W-1:0]         n_fill;
    logic [uiam_pkg::RING_AW-1:0]        n_wpos;
    logic                                n_above;
    logic [uiam_pkg::RUN_W:0]            n_run_inc;
    logic [uiam_pkg::PM_W-1:0]           n_avg;

    assign i_in.ready  = (r_state == S_IDLE) && i_rst_n;
    assign i_cfg.ready = i_rst_n;
    assign n_in_acc    = i_in.valid && i_in.ready;
    assign n_out_acc   = r_ov && o_out.ready;
    assign n_out_load  = (r_state == S_DONE) && (!r_ov || o_out.ready);

    assign o_out.valid                = r_ov;
    assign o_out.measured             = r_o_measured;
    assign o_out.utilization_permille = r_o_util;
    assign o_out.window_full          = r_o_full;
    assign o_out.average_permille     = r_o_avg;
    assign o_out.low_run_before       = r_o_before;
    assign o_out.alert                = r_o_alert;

    assign n_busy_sh = uiam_pkg::PROD_W'(r_busy) << r_j;
    assign n_td_sh   = uiam_pkg::PROD_W'(r_td) << r_j;
    assign n_thr_ext = uiam_pkg::PM_W'(r_thr);

    always_comb begin
        if (r_td_zero) begin
            n_util = '0;
        end else if (r_sat) begin
            n_util = uiam_pkg::PERMILLE_FULL;
        end else begin
            n_util = r_q;
        end
        if (r_fill == uiam_pkg::FILL_W'(uiam_pkg::WINDOW)) begin
            n_sum  = r_sum - uiam_pkg::SUM_W'(r_ring_rd) + uiam_pkg::SUM_W'(n_util);
            n_fill = r_fill;
        end else begin
            n_sum  = r_sum + uiam_pkg::SUM_W'(n_util);
            n_fill = r_fill + 1'b1;
        end
        if (r_wpos == uiam_pkg::RING_AW'(uiam_pkg::WINDOW - 1)) begin
            n_wpos = '0;
        end else begin
            n_wpos = r_wpos + 1'b1;
        end
        n_above   = r_p100 > r_pthr;
        n_run_inc = {1'b0, r_low_run} + 1'b1;
        if (r_res_full) begin
            n_avg = r_avg_prod[uiam_pkg::AVG_SHIFT +: uiam_pkg::PM_W];
        end else begin
            n_avg = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_j         <= '0;
            r_have_base <= 1'b0;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_low_run   <= '0;
            r_thr       <= uiam_pkg::THR_RESET;
            r_limit     <= uiam_pkg::LIMIT_RESET;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    uiam_pkg::CFG_THRESHOLD: r_thr   <= i_cfg.data[uiam_pkg::THR_W-1:0];
                    uiam_pkg::CFG_LIMIT:     r_limit <= i_cfg.data[uiam_pkg::RUN_W-1:0];
                    default: ;
                endcase
            end

            if (n_out_load) begin
                r_ov <= 1'b1;
            end else if (n_out_acc) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_k     <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 3'(uiam_pkg::NUM_TICK - 1)) begin
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    if (!r_have_base) begin
                        r_have_base <= 1'b1;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    r_j     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_j == uiam_pkg::STEP_W'(uiam_pkg::PM_W - 1)) begin
                        r_state <= S_DIV;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_j == '0) begin
                        r_state <= S_RING;
                    end else begin
                        r_j <= r_j - 1'b1;
                    end
                end
                S_RING: begin
                    r_sum   <= n_sum;
                    r_fill  <= n_fill;
                    r_wpos  <= n_wpos;
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    if (r_res_full) begin
                        if (n_above) begin
                            r_low_run <= '0;
                        end else if (n_run_inc >= {1'b0, r_limit}) begin
                            r_low_run <= '0;
                        end else begin
                            r_low_run <= n_run_inc[uiam_pkg::RUN_W-1:0];
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (n_in_acc) begin
                    r_field[0] <= i_in.user_ticks;
                    r_field[1] <= i_in.nice_ticks;
                    r_field[2] <= i_in.system_ticks;
                    r_field[3] <= i_in.idle_ticks;
                    r_field[4] <= i_in.iowait_ticks;
                    r_field[5] <= i_in.irq_ticks;
                    r_field[6] <= i_in.softirq_ticks;
                    r_field[7] <= i_in.steal_ticks;
                    r_idle     <= i_in.idle_ticks + i_in.iowait_ticks;
                    r_total    <= '0;
                end
            end
            S_SUM: begin
                r_total <= r_total + r_field[r_k];
            end
            S_DELTA: begin
                r_last_total <= r_total;
                r_prev_idle  <= r_idle;
                r_td         <= r_total - r_last_total;
                r_id         <= r_idle - r_prev_idle;
                r_res_measured <= r_have_base;
                r_res_util     <= '0;
                r_res_full     <= 1'b0;
                r_res_before   <= r_low_run;
                r_res_alert    <= 1'b0;
            end
            S_BUSY: begin
                r_td_zero <= (r_td == '0);
                r_busy    <= (r_td == '0) ? '0 : r_td - r_id;
                r_num     <= '0;
                r_p100    <= '0;
                r_pthr    <= '0;
                r_q       <= '0;
            end
            S_MUL: begin
                r_sat <= r_busy >= r_td;
                if (uiam_pkg::PERMILLE_FULL[r_j]) begin
                    r_num <= r_num + n_busy_sh;
                end
                if (uiam_pkg::PERCENT_FULL[r_j]) begin
                    r_p100 <= r_p100 + n_busy_sh;
                end
                if (n_thr_ext[r_j]) begin
                    r_pthr <= r_pthr + n_td_sh;
                end
            end
            S_DIV: begin
                if (r_num >= n_td_sh) begin
                    r_num    <= r_num - n_td_sh;
                    r_q[r_j] <= 1'b1;
                end
            end
            S_RING: begin
                r_res_util <= n_util;
                r_res_full <= (n_fill == uiam_pkg::FILL_W'(uiam_pkg::WINDOW));
                r_avg_prod <= uiam_pkg::AVG_PROD_W'(n_sum)
                              * uiam_pkg::AVG_PROD_W'(uiam_pkg::AVG_MULT);
            end
            S_AVG: begin
                if (r_res_full && !n_above && n_run_inc >= {1'b0, r_limit}) begin
                    r_res_alert <= 1'b1;
                end
            end
            S_DONE: begin
                if (n_out_load) begin
                    r_o_measured <= r_res_measured;
                    r_o_util     <= r_res_util;
                    r_o_full     <= r_res_full;
                    r_o_avg      <= n_avg;
                    r_o_before   <= r_res_before;
                    r_o_alert    <= r_res_alert;
                end
            end
            default: ;
        endcase
    end

    // ring memory: read before update, write back the new reading
    always_ff @(posedge i_clk) begin
        if (r_state == S_BUSY) begin
            r_ring_rd <= r_ring[r_wpos];
        end
        if (r_state == S_RING) begin
            r_ring[r_wpos] <= n_util;
        end
    end

endmodule

@@ dv/tb.sv @@
// Testbench for utilization_idle_alarm_monitor: streams tick-counter snapshots,
// predicts every result beat in place and checks it field by field.
// Depends on uiam_pkg, the channel interfaces in uiam_if.sv and the RTL top.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [uiam_pkg::TICK_W-1:0] user;
        logic [uiam_pkg::TICK_W-1:0] nice;
        logic [uiam_pkg::TICK_W-1:0] sys;
        logic [uiam_pkg::TICK_W-1:0] idle;
        logic [uiam_pkg::TICK_W-1:0] iowait;
        logic [uiam_pkg::TICK_W-1:0] irq;
        logic [uiam_pkg::TICK_W-1:0] softirq;
        logic [uiam_pkg::TICK_W-1:0] steal;
    } t_snap;

    typedef struct packed {
        logic                       measured;
        logic [uiam_pkg::PM_W-1:0]  util;
        logic                       full;
        logic [uiam_pkg::PM_W-1:0]  avg;
        logic [uiam_pkg::RUN_W-1:0] run_before;
        logic                       alert;
    } t_usage;

    logic i_clk;
    logic i_rst_n;

    uiam_in_if  snap_ch ();
    uiam_out_if usage_ch ();
    uiam_cfg_if cfg_ch ();

    utilization_idle_alarm_monitor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (snap_ch),
        .o_out   (usage_ch),
        .i_cfg   (cfg_ch)
    );

    t_snap  pending_snaps [$];
    t_usage expected_usage [$];
    t_snap  held_snap;
    t_snap  gen_last;
    t_usage want;
    int     mismatches;
    int     src_idle_pct;
    int     snk_stall_pct;
    int     regime_pct;
    int     regime_left;

    logic [uiam_pkg::THR_W-1:0] thr_cfg;
    logic [uiam_pkg::RUN_W-1:0] limit_cfg;

    logic                        have_base;
    logic [uiam_pkg::TICK_W-1:0] last_total;
    logic [uiam_pkg::TICK_W-1:0] prev_idle;
    logic [uiam_pkg::PM_W-1:0]   ring_model [uiam_pkg::WINDOW];
    int                          ring_pos;
    int                          ring_count;
    int                          ring_total;
    int                          low_run;

    always #1 i_clk = ~i_clk;

    function automatic t_usage predict_usage(t_snap s);
        logic [uiam_pkg::TICK_W-1:0] idle_now;
        logic [uiam_pkg::TICK_W-1:0] total_now;
        logic [uiam_pkg::TICK_W-1:0] d_total;
        logic [uiam_pkg::TICK_W-1:0] d_idle;
        logic [uiam_pkg::TICK_W-1:0] busy;
        logic [uiam_pkg::PM_W-1:0]   util;
        t_usage                      r;
        r = '0;
        r.run_before = uiam_pkg::RUN_W'(low_run);
        idle_now = s.idle + s.iowait;
        total_now = idle_now + s.user + s.nice + s.sys + s.irq + s.softirq + s.steal;
        if (!have_base) begin
            have_base = 1'b1;
            last_total = total_now;
            prev_idle = idle_now;
            return r;
        end
        d_total = total_now - last_total;
        d_idle = idle_now - prev_idle;
        last_total = total_now;
        prev_idle = idle_now;
        if (d_total == '0) begin
            busy = '0;
            util = '0;
        end else begin
            busy = d_total - d_idle;
            if (busy >= d_total)
                util = uiam_pkg::PERMILLE_FULL;
            else
                util = uiam_pkg::PM_W'((128'(busy) * 128'd1000) / 128'(d_total));
        end
        if (ring_count >= uiam_pkg::WINDOW)
            ring_total -= int'(ring_model[ring_pos]);
        ring_model[ring_pos] = util;
        ring_total += int'(util);
        ring_pos = (ring_pos + 1 >= uiam_pkg::WINDOW) ? 0 : ring_pos + 1;
        if (ring_count < uiam_pkg::WINDOW)
            ring_count++;
        r.measured = 1'b1;
        r.util = util;
        if (ring_count >= uiam_pkg::WINDOW) begin
            r.full = 1'b1;
            r.avg = uiam_pkg::PM_W'(ring_total / uiam_pkg::WINDOW);
            if (128'(busy) * 128'd100 > 128'(d_total) * 128'(thr_cfg)) begin
                low_run = 0;
            end else begin
                low_run++;
                if (low_run >= int'(limit_cfg)) begin
                    r.alert = 1'b1;
                    low_run = 0;
                end
            end
            low_run &= 63;
        end
        return r;
    endfunction

    function automatic t_snap next_snapshot();
        t_snap                       s;
        logic [uiam_pkg::TICK_W-1:0] d_total;
        logic [uiam_pkg::TICK_W-1:0] d_busy;
        logic [uiam_pkg::TICK_W-1:0] rem;
        logic [uiam_pkg::TICK_W-1:0] part [6];
        logic [uiam_pkg::TICK_W-1:0] idle_part;
        int                          pick;
        int                          thr_cap;
        s = gen_last;
        pick = $urandom_range(99);
        thr_cap = (thr_cfg > 100) ? 100 : int'(thr_cfg);
        if (pick < 2) begin
            for (int k = 0; k < 16; k++)
                s[k*32 +: 32] = $urandom;
        end else if (pick < 3) begin
            s.idle -= uiam_pkg::TICK_W'($urandom_range(1, 5000));
            s.user += uiam_pkg::TICK_W'($urandom_range(0, 100));
        end else if (pick < 4) begin
            s.idle += uiam_pkg::TICK_W'($urandom_range(600, 3000));
            s.sys -= uiam_pkg::TICK_W'($urandom_range(1, 500));
        end else if (pick < 6) begin
            s = gen_last;
        end else begin
            if (regime_left == 0) begin
                regime_left = $urandom_range(1, 90);
                case ($urandom_range(3))
                    0: regime_pct = 0;
                    1: regime_pct = thr_cap;
                    2: regime_pct = $urandom_range(0, thr_cap);
                    default: regime_pct = $urandom_range(0, 100);
                endcase
            end
            regime_left--;
            pick = $urandom_range(9);
            if (pick < 6)
                d_total = uiam_pkg::TICK_W'($urandom_range(1, 2000));
            else if (pick < 8)
                d_total = uiam_pkg::TICK_W'(100 * $urandom_range(1, 50));
            else
                d_total = ({$urandom, $urandom} >> $urandom_range(8, 40)) + 1;
            d_busy = (d_total / 100) * regime_pct + ((d_total % 100) * regime_pct) / 100;
            if (pick < 3 && d_busy < d_total)
                d_busy += uiam_pkg::TICK_W'($urandom_range(0, 1));
            rem = d_busy;
            for (int k = 0; k < 5; k++) begin
                part[k] = (rem >> 8) * uiam_pkg::TICK_W'($urandom_range(0, 255));
                rem -= part[k];
            end
            part[5] = rem;
            idle_part = ((d_total - d_busy) >> 8) * uiam_pkg::TICK_W'($urandom_range(0, 255));
            s.user += part[0];
            s.nice += part[1];
            s.sys += part[2];
            s.irq += part[3];
            s.softirq += part[4];
            s.steal += part[5];
            s.idle += idle_part;
            s.iowait += d_total - d_busy - idle_part;
        end
        return s;
    endfunction

    task automatic push_snap(t_snap s);
        pending_snaps.push_back(s);
        gen_last = s;
    endtask

    task automatic check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    task automatic write_reg(logic [uiam_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= uiam_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == uiam_pkg::CFG_THRESHOLD)
            thr_cfg = uiam_pkg::THR_W'(val);
        else
            limit_cfg = uiam_pkg::RUN_W'(val);
    endtask

    task automatic wait_drained();
        while (pending_snaps.size() != 0 || snap_ch.valid || expected_usage.size() != 0)
            @(negedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_phase(int thr, int lim, int src, int snk, int n);
        write_reg(uiam_pkg::CFG_THRESHOLD, thr);
        write_reg(uiam_pkg::CFG_LIMIT, lim);
        @(negedge i_clk);
        src_idle_pct = src;
        snk_stall_pct = snk;
        repeat (n) push_snap(next_snapshot());
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snap_ch.valid <= 1'b0;
        end else begin
            if (snap_ch.valid && snap_ch.ready)
                expected_usage.push_back(predict_usage(held_snap));
            if (!snap_ch.valid || snap_ch.ready) begin
                if (pending_snaps.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    held_snap = pending_snaps.pop_front();
                    snap_ch.valid         <= 1'b1;
                    snap_ch.user_ticks    <= held_snap.user;
                    snap_ch.nice_ticks    <= held_snap.nice;
                    snap_ch.system_ticks  <= held_snap.sys;
                    snap_ch.idle_ticks    <= held_snap.idle;
                    snap_ch.iowait_ticks  <= held_snap.iowait;
                    snap_ch.irq_ticks     <= held_snap.irq;
                    snap_ch.softirq_ticks <= held_snap.softirq;
                    snap_ch.steal_ticks   <= held_snap.steal;
                end else begin
                    snap_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            usage_ch.ready <= 1'b0;
        end else begin
            usage_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
            if (usage_ch.valid && usage_ch.ready) begin
                if (expected_usage.size() == 0) begin
                    $display("%0t: result beat expected none, got util %0d", $time,
                             usage_ch.utilization_permille);
                    mismatches++;
                end else begin
                    want = expected_usage.pop_front();
                    check_field("measured", want.measured, usage_ch.measured);
                    check_field("utilization_permille", want.util,
                                usage_ch.utilization_permille);
                    check_field("window_full", want.full, usage_ch.window_full);
                    check_field("average_permille", want.avg, usage_ch.average_permille);
                    check_field("low_run_before", want.run_before, usage_ch.low_run_before);
                    check_field("alert", want.alert, usage_ch.alert);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_snap s;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        snap_ch.valid = 1'b0;
        snap_ch.user_ticks = '0;
        snap_ch.nice_ticks = '0;
        snap_ch.system_ticks = '0;
        snap_ch.idle_ticks = '0;
        snap_ch.iowait_ticks = '0;
        snap_ch.irq_ticks = '0;
        snap_ch.softirq_ticks = '0;
        snap_ch.steal_ticks = '0;
        usage_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = uiam_pkg::CFG_THRESHOLD;
        cfg_ch.data = '0;
        held_snap = '0;
        gen_last = '0;
        mismatches = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        regime_pct = 0;
        regime_left = 0;
        thr_cfg = uiam_pkg::THR_RESET;
        limit_cfg = uiam_pkg::LIMIT_RESET;
        have_base = 1'b0;
        last_total = '0;
        prev_idle = '0;
        ring_pos = 0;
        ring_count = 0;
        ring_total = 0;
        low_run = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // baseline, zero delta, wrapped counters and saturation corners
        s = '0;
        push_snap(s);
        push_snap(s);
        s = '1;
        push_snap(s);
        push_snap(s);
        s.idle += 100;
        push_snap(s);
        s.user += 100;
        push_snap(s);
        s.user += 1;
        s.idle += 2;
        push_snap(s);
        s.user += 30;
        s.iowait += 70;
        push_snap(s);
        s.idle -= 50;
        s.user += 100;
        push_snap(s);
        s.idle += 1000;
        s.sys -= 500;
        push_snap(s);
        s = {8{64'hAAAA_AAAA_AAAA_AAAA}};
        push_snap(s);
        s = {8{64'h5555_5555_5555_5555}};
        push_snap(s);
        s.steal += 64'hFFFF_FFFF_FFFF_FFFF;
        push_snap(s);
        s.softirq += 1;
        s.irq += 1;
        s.nice += 1;
        s.idle += 1;
        push_snap(s);
        s.user += 999;
        s.iowait += 1;
        push_snap(s);
        wait_drained();

        run_phase(30, 30, 0, 0, 300);
        run_phase(0, 1, 62, 0, 200);
        run_phase(100, 63, 0, 62, 240);
        run_phase(127, 5, 33, 33, 200);
        run_phase(50, 0, 0, 0, 200);
        // build a long low run, then drop the limit under it
        run_phase(100, 63, 33, 33, 50);
        run_phase(70, 4, 33, 33, 220);
        run_phase(30, 30, 0, 0, 200);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
